@@ design/preset_recall_knob_catch_fsm_defines.svh @@
// Assertion macros used by the checker file.
`ifndef PRESET_RECALL_KNOB_CATCH_FSM_DEFINES_SVH
`define PRESET_RECALL_KNOB_CATCH_FSM_DEFINES_SVH

// Same-cycle implication on clk, off while rst is high.
`define PRKC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication on clk, off while rst is high.
`define PRKC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/prkc_pkg.sv @@
package prkc_pkg;

  localparam int NUM_KNOBS  = 8;
  localparam int KNOB_CNT_W = (NUM_KNOBS > 1) ? $clog2(NUM_KNOBS) : 1;

  localparam int POT_W     = 12;
  localparam int IDX_W     = 3;
  localparam int MS_W      = 16;
  localparam int DT_W      = 8;
  localparam int CH_W      = 8;
  localparam int FLOOR_W   = 9;
  localparam int DVD_W     = MS_W + 1;
  localparam int STEP_W    = 5;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;

  // serial divider step counts
  localparam logic [STEP_W-1:0] MOD_STEPS = STEP_W'(DVD_W);
  localparam logic [STEP_W-1:0] DIV_STEPS = STEP_W'(FLOOR_W);

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_CATCH_TOL     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLASH_DUR     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BREATHE_PER   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BREATHE_FLOOR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_RED     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_GREEN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_BLUE    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RECALL_RED    = 3'd7;

  // register reset values
  localparam logic [POT_W-1:0]   RST_CATCH_TOL     = 12'd123;
  localparam logic [MS_W-1:0]    RST_FLASH_DUR     = 16'd750;
  localparam logic [MS_W-1:0]    RST_BREATHE_PER   = 16'd1500;
  localparam logic [FLOOR_W-1:0] RST_BREATHE_FLOOR = 9'd102;
  localparam logic [CH_W-1:0]    RST_WHITE_RED     = 8'd179;
  localparam logic [CH_W-1:0]    RST_WHITE_GREEN   = 8'd230;
  localparam logic [CH_W-1:0]    RST_WHITE_BLUE    = 8'd230;
  localparam logic [CH_W-1:0]    RST_RECALL_RED    = 8'd255;

  localparam logic [FLOOR_W-1:0] Q8_ONE = 9'd256;

  typedef enum logic [2:0] {
    CMD_MOVE     = 3'd0,
    CMD_RECALL   = 3'd1,
    CMD_HOLD     = 3'd2,
    CMD_COMMIT   = 3'd3,
    CMD_SNAPSHOT = 3'd4,
    CMD_TICK     = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_LIVE   = 2'd0,
    MODE_PRESET = 2'd1,
    MODE_ARMED  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_MOVE_LIVE,
    OP_MOVE_CATCH,
    OP_REALIGN,
    OP_COMMIT_ALL,
    OP_WRITE
  } knob_op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_MUL,
    ST_DIV,
    ST_SCALE,
    ST_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic [POT_W-1:0] live;
    logic [POT_W-1:0] saved;
    logic             aligned;
  } knob_t;

  localparam knob_t KNOB_RESET = '{live: '0, saved: '0, aligned: 1'b1};

  // what the head knob saw on a catch move
  typedef struct packed {
    logic on;
    logic was_aligned;
  } knob_evt_t;

  typedef struct packed {
    logic              start;
    logic [MS_W-1:0]   rem_init;
    logic [DVD_W-1:0]  dividend;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  function automatic logic near_spot(input logic [POT_W-1:0] a,
                                     input logic [POT_W-1:0] b,
                                     input logic [POT_W-1:0] tol);
    logic [POT_W-1:0] diff;
    diff = (a > b) ? (a - b) : (b - a);
    return diff <= tol;
  endfunction

  function automatic logic idx_hit(input logic [KNOB_CNT_W-1:0] cnt,
                                   input logic [IDX_W-1:0] idx);
    return int'(cnt) == int'(idx);
  endfunction

endpackage

@@ design/prkc_cell.sv @@
// One knob slot of the ring: loads its neighbor's entry on every shift.
module prkc_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            shift_en,
  input  prkc_pkg::knob_t din,
  output prkc_pkg::knob_t q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q <= prkc_pkg::KNOB_RESET;
    end else if (shift_en) begin
      q <= din;
    end
  end

endmodule

@@ design/prkc_knob_op.sv @@
// Update applied to the knob entry leaving the ring head.
module prkc_knob_op (
  input  prkc_pkg::knob_op_t               op,
  input  logic                             hit,
  input  logic [prkc_pkg::POT_W-1:0]       pot_value,
  input  logic [prkc_pkg::POT_W-1:0]       tol,
  input  prkc_pkg::knob_t                  head,
  output prkc_pkg::knob_t                  result,
  output prkc_pkg::knob_evt_t              evt
);

  logic on_move;
  logic on_rest;

  always_comb begin
    on_move = prkc_pkg::near_spot(pot_value, head.saved, tol);
    on_rest = prkc_pkg::near_spot(head.live, head.saved, tol);
    evt.on          = on_move;
    evt.was_aligned = head.aligned;
    result          = head;
    unique case (op)
      prkc_pkg::OP_NONE: begin
      end
      prkc_pkg::OP_MOVE_LIVE: begin
        if (hit) result.live = pot_value;
      end
      prkc_pkg::OP_MOVE_CATCH: begin
        if (hit) begin
          result.live    = pot_value;
          result.aligned = on_move;
        end
      end
      prkc_pkg::OP_REALIGN: begin
        result.aligned = on_rest;
      end
      prkc_pkg::OP_COMMIT_ALL: begin
        result.saved   = head.live;
        result.aligned = 1'b1;
      end
      prkc_pkg::OP_WRITE: begin
        if (hit) begin
          result.saved   = pot_value;
          result.aligned = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ design/prkc_divider.sv @@
// Restoring divider, one quotient bit per cycle, dividend shifted in MSB first.
module prkc_divider (
  input  logic                           clk,
  input  logic                           rst,
  input  prkc_pkg::div_req_t             req,
  input  logic [prkc_pkg::MS_W-1:0]      divisor,
  output logic                           done,
  output logic [prkc_pkg::MS_W-1:0]      rem,
  output logic [prkc_pkg::DVD_W-1:0]     quo
);

  logic                              busy;
  logic [prkc_pkg::STEP_W-1:0]       cnt;
  logic [prkc_pkg::DVD_W-1:0]        dvd;
  logic [prkc_pkg::DVD_W-1:0]        trial;
  logic [prkc_pkg::DVD_W-1:0]        diff;
  logic                              fits;

  always_comb begin
    trial = {rem, dvd[prkc_pkg::DVD_W-1]};
    fits  = trial >= {1'b0, divisor};
    diff  = trial - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == prkc_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder stays below the divisor, so 16 bits hold it
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= req.rem_init;
      dvd <= req.dividend;
      quo <= '0;
    end else if (busy) begin
      rem <= fits ? diff[prkc_pkg::MS_W-1:0] : trial[prkc_pkg::MS_W-1:0];
      dvd <= {dvd[prkc_pkg::DVD_W-2:0], 1'b0};
      quo <= {quo[prkc_pkg::DVD_W-2:0], fits};
    end
  end

endmodule

@@ design/preset_recall_knob_catch_fsm.sv @@
// Channel  | Dir | Handshake          | Contents
// ---------+-----+--------------------+-------------------------------------------
// s_       | in  | s_tvalid/s_tready  | one command: knob move, recall, hold,
//          |     |                    | element write, ms tick
// m_       | out | m_tvalid/m_tready  | mode, LED on and RGB, saved value readback
// cfg_     | in  | cfg_valid/cfg_ready| register index and write data
//
// Every command passes through the serial divider from transfer to result: a
// 17-step modulo then a 9-step divide for the breathe level. The knob ring
// sweep overlaps the modulo.
// One item is in flight at a time; s_tready is high only when the core is idle.
// A finished result waits in the output register, and the next item may be
// taken meanwhile; it completes only once the register has been read.
// rst is synchronous: knobs, mode and timers return to their idle values and
// all config registers to their defaults. cfg_ready is always high.
module preset_recall_knob_catch_fsm (
  input  logic        clk,
  input  logic        rst,
  // [2:0] pot_index, [14:3] pot_value, [22:15] elapsed_ms, [23] zero
  input  logic [23:0] s_tdata,
  // [2:0] cmd
  input  logic [2:0]  s_tuser,
  input  logic        s_tlast,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [1:0] mode_now, [2] led_on, [10:3] led_red, [18:11] led_green,
  // [26:19] led_blue, [38:27] saved_value, [39] zero
  output logic [39:0] m_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic [prkc_pkg::KNOB_CNT_W-1:0] KNOB_LAST =
    prkc_pkg::KNOB_CNT_W'(prkc_pkg::NUM_KNOBS - 1);

  // ---------------------------------------------------------------- inputs
  logic [prkc_pkg::IDX_W-1:0] in_idx;
  logic [prkc_pkg::POT_W-1:0] in_val;
  logic [prkc_pkg::DT_W-1:0]  in_dt;
  logic [2:0]                 in_cmd;
  logic                       in_last;

  assign in_idx  = s_tdata[2:0];
  assign in_val  = s_tdata[14:3];
  assign in_dt   = s_tdata[22:15];
  assign in_cmd  = s_tuser;
  assign in_last = s_tlast;

  // ------------------------------------------------------- config registers
  logic [prkc_pkg::POT_W-1:0]   catch_tol;
  logic [prkc_pkg::MS_W-1:0]    flash_dur;
  logic [prkc_pkg::MS_W-1:0]    breathe_per;
  logic [prkc_pkg::FLOOR_W-1:0] breathe_floor;
  logic [prkc_pkg::CH_W-1:0]    white_red;
  logic [prkc_pkg::CH_W-1:0]    white_green;
  logic [prkc_pkg::CH_W-1:0]    white_blue;
  logic [prkc_pkg::CH_W-1:0]    recall_red;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      catch_tol     <= prkc_pkg::RST_CATCH_TOL;
      flash_dur     <= prkc_pkg::RST_FLASH_DUR;
      breathe_per   <= prkc_pkg::RST_BREATHE_PER;
      breathe_floor <= prkc_pkg::RST_BREATHE_FLOOR;
      white_red     <= prkc_pkg::RST_WHITE_RED;
      white_green   <= prkc_pkg::RST_WHITE_GREEN;
      white_blue    <= prkc_pkg::RST_WHITE_BLUE;
      recall_red    <= prkc_pkg::RST_RECALL_RED;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        prkc_pkg::REG_CATCH_TOL:     catch_tol     <= cfg_data[11:0];
        prkc_pkg::REG_FLASH_DUR:     flash_dur     <= cfg_data;
        prkc_pkg::REG_BREATHE_PER:   breathe_per   <= cfg_data;
        prkc_pkg::REG_BREATHE_FLOOR: breathe_floor <= cfg_data[8:0];
        prkc_pkg::REG_WHITE_RED:     white_red     <= cfg_data[7:0];
        prkc_pkg::REG_WHITE_GREEN:   white_green   <= cfg_data[7:0];
        prkc_pkg::REG_WHITE_BLUE:    white_blue    <= cfg_data[7:0];
        prkc_pkg::REG_RECALL_RED:    recall_red    <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  // floor above unity counts as unity
  logic [prkc_pkg::FLOOR_W-1:0] floor_cl;
  logic [prkc_pkg::FLOOR_W-1:0] floor_span;
  logic                         per_zero;

  assign floor_cl   = (breathe_floor > prkc_pkg::Q8_ONE) ? prkc_pkg::Q8_ONE : breathe_floor;
  assign floor_span = prkc_pkg::Q8_ONE - floor_cl;
  assign per_zero   = (breathe_per == '0);

  // ------------------------------------------------------------- knob ring
  // Entries rotate one slot toward the head per shift; the head entry passes
  // through the update logic into the tail. After NUM_KNOBS shifts every knob
  // is back in its own slot.
  prkc_pkg::knob_t     ring_q [prkc_pkg::NUM_KNOBS];
  prkc_pkg::knob_t     knob_new;
  prkc_pkg::knob_evt_t knob_evt;
  logic                shift_en;
  logic                hit;

  for (genvar j = 0; j < prkc_pkg::NUM_KNOBS; j++) begin : g_ring
    if (j == prkc_pkg::NUM_KNOBS - 1) begin : g_tail
      prkc_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift_en (shift_en),
        .din      (knob_new),
        .q        (ring_q[j])
      );
    end else begin : g_link
      prkc_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift_en (shift_en),
        .din      (ring_q[j+1]),
        .q        (ring_q[j])
      );
    end
  end

  // ------------------------------------------------------------ item state
  prkc_pkg::ctrl_state_t state, state_next;
  prkc_pkg::mode_t       cur_mode, mode_next;
  prkc_pkg::mode_t       mode_before_arm, mba_next;
  prkc_pkg::knob_op_t    op_q, op_next;
  logic                  has_saved, has_saved_next;
  logic [prkc_pkg::MS_W-1:0] flash_left, flash_next;
  logic [prkc_pkg::MS_W-1:0] breathe_pos, pos_next;
  logic                  sweeping, sweeping_next;
  logic [prkc_pkg::KNOB_CNT_W-1:0] kcnt, kcnt_next;

  logic [2:0]                 cmd_q;
  logic [prkc_pkg::IDX_W-1:0] idx_q;
  logic [prkc_pkg::POT_W-1:0] val_q;
  logic [prkc_pkg::POT_W-1:0] saved_rd;
  logic [prkc_pkg::MS_W-1:0]  n_q, n_next;
  logic [prkc_pkg::FLOOR_W-1:0] k_q, k_next;
  logic [prkc_pkg::CH_W-1:0]  r_s, g_s, b_s;

  logic accept;
  logic load_out;

  assign hit = prkc_pkg::idx_hit(kcnt, idx_q);

  prkc_knob_op u_knob_op (
    .op        (op_q),
    .hit       (hit),
    .pot_value (val_q),
    .tol       (catch_tol),
    .head      (ring_q[0]),
    .result    (knob_new),
    .evt       (knob_evt)
  );

  // ------------------------------------------------------ shared divider
  prkc_pkg::div_req_t            div_req;
  logic                          div_done;
  logic [prkc_pkg::MS_W-1:0]     div_rem;
  logic [prkc_pkg::DVD_W-1:0]    div_quo;

  prkc_divider u_divider (
    .clk     (clk),
    .rst     (rst),
    .req     (div_req),
    .divisor (breathe_per),
    .done    (div_done),
    .rem     (div_rem),
    .quo     (div_quo)
  );

  // triangle position from the reduced breathe time
  logic [prkc_pkg::MS_W-1:0]  tri_t;
  logic [prkc_pkg::DVD_W-1:0] tri_2t;
  logic [prkc_pkg::DVD_W-1:0] tri_2p;
  logic [24:0]                brt_prod;

  assign tri_t    = per_zero ? '0 : div_rem;
  assign tri_2t   = {tri_t, 1'b0};
  assign tri_2p   = {breathe_per, 1'b0};
  assign brt_prod = 25'(floor_span) * 25'(n_q);

  always_comb begin
    state_next     = state;
    mode_next      = cur_mode;
    mba_next       = mode_before_arm;
    has_saved_next = has_saved;
    flash_next     = flash_left;
    pos_next       = breathe_pos;
    op_next        = op_q;
    sweeping_next  = sweeping;
    kcnt_next      = kcnt;
    n_next         = n_q;
    k_next         = k_q;
    div_req        = '0;
    accept         = 1'b0;
    load_out       = 1'b0;
    shift_en       = 1'b0;

    // ring sweep runs alongside the arithmetic
    if (sweeping) begin
      shift_en  = 1'b1;
      kcnt_next = kcnt + 1'b1;
      if (kcnt == KNOB_LAST) begin
        sweeping_next = 1'b0;
        kcnt_next     = '0;
      end
      if (hit && op_q == prkc_pkg::OP_MOVE_CATCH) begin
        if (knob_evt.on && !knob_evt.was_aligned) begin
          flash_next = flash_dur;
        end else if (!knob_evt.on && knob_evt.was_aligned) begin
          flash_next = '0;
        end
      end
    end

    unique case (state)
      prkc_pkg::ST_IDLE: begin
        if (s_tvalid) begin
          accept        = 1'b1;
          state_next    = prkc_pkg::ST_MOD;
          sweeping_next = 1'b1;
          kcnt_next     = '0;
          op_next       = prkc_pkg::OP_NONE;
          unique case (in_cmd) inside
            prkc_pkg::CMD_MOVE: begin
              op_next = (cur_mode == prkc_pkg::MODE_PRESET) ?
                        prkc_pkg::OP_MOVE_CATCH : prkc_pkg::OP_MOVE_LIVE;
            end
            prkc_pkg::CMD_RECALL: begin
              if (cur_mode == prkc_pkg::MODE_PRESET) begin
                mode_next = prkc_pkg::MODE_LIVE;
              end else if (cur_mode == prkc_pkg::MODE_ARMED) begin
                // cancel: back where hold was pressed
                mode_next = mode_before_arm;
                if (mode_before_arm == prkc_pkg::MODE_PRESET) begin
                  op_next = prkc_pkg::OP_REALIGN;
                end
              end else if (has_saved) begin
                mode_next = prkc_pkg::MODE_PRESET;
                op_next   = prkc_pkg::OP_REALIGN;
              end
            end
            prkc_pkg::CMD_HOLD: begin
              if (cur_mode == prkc_pkg::MODE_ARMED) begin
                op_next        = prkc_pkg::OP_COMMIT_ALL;
                has_saved_next = 1'b1;
                mode_next      = prkc_pkg::MODE_PRESET;
              end else begin
                mba_next  = cur_mode;
                mode_next = prkc_pkg::MODE_ARMED;
                pos_next  = '0;
              end
            end
            prkc_pkg::CMD_COMMIT, prkc_pkg::CMD_SNAPSHOT: begin
              op_next = prkc_pkg::OP_WRITE;
              if (in_last) begin
                has_saved_next = 1'b1;
                if (in_cmd == prkc_pkg::CMD_COMMIT) mode_next = prkc_pkg::MODE_PRESET;
              end
            end
            prkc_pkg::CMD_TICK: begin
              if (flash_left != '0) begin
                flash_next = (flash_left > prkc_pkg::MS_W'(in_dt)) ?
                             flash_left - prkc_pkg::MS_W'(in_dt) : '0;
              end
            end
            default: begin
            end
          endcase
          // reduce the breathe time modulo the current period
          div_req.start    = 1'b1;
          div_req.rem_init = '0;
          div_req.dividend = (in_cmd == prkc_pkg::CMD_TICK) ?
                             ({1'b0, breathe_pos} + prkc_pkg::DVD_W'(in_dt)) :
                             {1'b0, pos_next};
          div_req.steps    = prkc_pkg::MOD_STEPS;
        end
      end
      prkc_pkg::ST_MOD: begin
        if (div_done) begin
          if (cmd_q == prkc_pkg::CMD_TICK) pos_next = tri_t;
          n_next     = (tri_2t < {1'b0, breathe_per}) ?
                       tri_2t[prkc_pkg::MS_W-1:0] :
                       prkc_pkg::MS_W'(tri_2p - tri_2t);
          state_next = prkc_pkg::ST_MUL;
        end
      end
      prkc_pkg::ST_MUL: begin
        // quotient stays at or below 256, so the top 15 bits start below P
        div_req.start    = 1'b1;
        div_req.rem_init = {1'b0, brt_prod[23:9]};
        div_req.dividend = {brt_prod[8:0], 8'b0};
        div_req.steps    = prkc_pkg::DIV_STEPS;
        state_next       = prkc_pkg::ST_DIV;
      end
      prkc_pkg::ST_DIV: begin
        if (div_done) begin
          k_next     = per_zero ? floor_cl : floor_cl + div_quo[prkc_pkg::FLOOR_W-1:0];
          state_next = prkc_pkg::ST_SCALE;
        end
      end
      prkc_pkg::ST_SCALE: begin
        state_next = prkc_pkg::ST_OUT;
      end
      prkc_pkg::ST_OUT: begin
        if (!sweeping && (!m_tvalid || m_tready)) begin
          load_out   = 1'b1;
          state_next = prkc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = prkc_pkg::ST_IDLE;
      end
    endcase
  end

  assign s_tready = (state == prkc_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= prkc_pkg::ST_IDLE;
      cur_mode        <= prkc_pkg::MODE_LIVE;
      mode_before_arm <= prkc_pkg::MODE_LIVE;
      has_saved       <= 1'b0;
      flash_left      <= '0;
      breathe_pos     <= '0;
      op_q            <= prkc_pkg::OP_NONE;
      sweeping        <= 1'b0;
      kcnt            <= '0;
    end else begin
      state           <= state_next;
      cur_mode        <= mode_next;
      mode_before_arm <= mba_next;
      has_saved       <= has_saved_next;
      flash_left      <= flash_next;
      breathe_pos     <= pos_next;
      op_q            <= op_next;
      sweeping        <= sweeping_next;
      kcnt            <= kcnt_next;
    end
  end

  function automatic logic [prkc_pkg::CH_W-1:0] scale_q8(
      input logic [prkc_pkg::CH_W-1:0]    c,
      input logic [prkc_pkg::FLOOR_W-1:0] k);
    logic [16:0] v;
    v = 17'(c) * 17'(k) + 17'd128;
    return (v[16:8] > 9'd255) ? 8'hFF : v[15:8];
  endfunction

  // item payload
  always_ff @(posedge clk) begin
    n_q <= n_next;
    k_q <= k_next;
    if (accept) begin
      cmd_q    <= in_cmd;
      idx_q    <= in_idx;
      val_q    <= in_val;
      saved_rd <= '0;
    end else if (sweeping && hit) begin
      saved_rd <= knob_new.saved;
    end
    if (state == prkc_pkg::ST_SCALE) begin
      r_s <= scale_q8(white_red, k_q);
      g_s <= scale_q8(white_green, k_q);
      b_s <= scale_q8(white_blue, k_q);
    end
  end

  // ---------------------------------------------------------- result
  logic [prkc_pkg::CH_W-1:0] led_r, led_g, led_b;

  always_comb begin
    if (cur_mode == prkc_pkg::MODE_ARMED) begin
      led_r = r_s;
      led_g = g_s;
      led_b = b_s;
    end else if (flash_left != '0) begin
      led_r = white_red;
      led_g = white_green;
      led_b = white_blue;
    end else begin
      led_r = recall_red;
      led_g = '0;
      led_b = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= {1'b0, saved_rd, led_b, led_g, led_r,
                  (cur_mode != prkc_pkg::MODE_LIVE), cur_mode};
    end
  end

endmodule

@@ design/prkc_checker.sv @@
`include "preset_recall_knob_catch_fsm_defines.svh"

module prkc_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata
);

  `PRKC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")
  `PRKC_ASSERT_NOW(a_led_on, m_tvalid, m_tdata[2] == (m_tdata[1:0] != 2'd0), "led_on disagrees with mode")
  `PRKC_ASSERT_NEXT(a_single_item, s_tvalid && s_tready, !s_tready, "second item taken while busy")
  `PRKC_ASSERT_NEXT(a_no_early_result, s_tvalid && s_tready, !$rose(m_tvalid), "result right after transfer")

endmodule

bind preset_recall_knob_catch_fsm prkc_checker u_prkc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
